// ----- rtl/core/ols_pkg.sv -----
// ----------------------------------------------------------------------------
// ols_pkg
// Shared types and constants of the ordered list store: request kinds,
// result status codes, fixed field widths and default parameter values.
// ----------------------------------------------------------------------------
package ols_pkg;

   localparam int KIND_W   = 2;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   localparam int DEF_CAPACITY    = 16;
   localparam int DEF_VALUE_WIDTH = 32;

   typedef enum logic [KIND_W-1:0] {
      KIND_APPEND       = 2'd0,
      KIND_REMOVE_FIRST = 2'd1,
      KIND_REMOVE_LAST  = 2'd2,
      KIND_REMOVE_MATCH = 2'd3
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE     = 2'd0,
      ST_EMPTY    = 2'd1,
      ST_NOTFOUND = 2'd2,
      ST_FULL     = 2'd3
   } status_type;

endpackage

// ----- rtl/core/ols_req_if.sv -----
// ----------------------------------------------------------------------------
// ols_req_if
// Request channel of the ordered list store: valid/ready handshake with the
// request kind and the value to append or to search for.
// ----------------------------------------------------------------------------
interface ols_req_if;

   logic                              valid;
   logic                              ready;
   ols_pkg::kind_type                 kind;
   logic signed [ols_pkg::DATA_W-1:0] value;

   modport source (output valid, output kind, output value, input ready);
   modport sink   (input valid, input kind, input value, output ready);

endinterface

// ----- rtl/core/ols_rsp_if.sv -----
// ----------------------------------------------------------------------------
// ols_rsp_if
// Result channel of the ordered list store: valid/ready handshake with the
// status, the removed value and the entry count after the request.
// ----------------------------------------------------------------------------
interface ols_rsp_if;

   logic                              valid;
   logic                              ready;
   ols_pkg::status_type               status;
   logic signed [ols_pkg::DATA_W-1:0] removed_value;
   logic [ols_pkg::COUNT_W-1:0]       entry_count;

   modport source (output valid, output status, output removed_value,
                   output entry_count, input ready);
   modport sink   (input valid, input status, input removed_value,
                   input entry_count, output ready);

endinterface

// ----- rtl/core/ols_ram.sv -----
// ----------------------------------------------------------------------------
// ols_ram
// Generic single write port, single read port RAM with registered read data.
// Contents are undefined until written.
// ----------------------------------------------------------------------------
module ols_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/ordered_list_store_core.sv -----
// ----------------------------------------------------------------------------
// ordered_list_store_core
// Bounded ordered list of signed words kept as a doubly linked store.
//
// Requests arrive on req_if (valid/ready): append at the tail, remove the
// head, remove the tail, or remove the first entry from the head whose value
// matches. Every request gives exactly one item on rsp_if with a status
// (done, empty, not found, full), the removed value (zero when nothing is
// removed) and the entry count after the request.
// Entries live in one RAM holding value, next and prev link per slot; freed
// slots are stacked in a second RAM, untouched slots are handed out by a
// fill mark, so no clearing pass is needed after reset.
// An append passes through alloc (recycled slot only), append, link
// (non-empty list only) and done; a request refused as full or empty goes
// straight to done. A removal passes through search, the fix states for a
// middle entry, and done: the search reads one entry per cycle from the
// entry RAM. The result is registered in an output register.
// req_if.ready is high while the sequencer is idle; a stalled result holds
// in the output register while the next request is taken, and that request
// finishes only once the output register is free.
// Synchronous reset empties the list and drops any pending result.
// ----------------------------------------------------------------------------
module ordered_list_store_core #(
   parameter int CAPACITY    = ols_pkg::DEF_CAPACITY,
   parameter int VALUE_WIDTH = ols_pkg::DEF_VALUE_WIDTH
) (
   input  logic         clock,
   input  logic         reset,
   ols_req_if.sink      req_if,
   ols_rsp_if.source    rsp_if
);

   localparam int SW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int VW = VALUE_WIDTH;
   localparam int EW = VW + 2 * SW;
   localparam int XW = (VW > ols_pkg::DATA_W) ? VW : ols_pkg::DATA_W;

   typedef enum logic [7:0] {
      S_IDLE   = 8'b0000_0001,
      S_ALLOC  = 8'b0000_0010,
      S_APPEND = 8'b0000_0100,
      S_LINK   = 8'b0000_1000,
      S_SEARCH = 8'b0001_0000,
      S_FIX_P  = 8'b0010_0000,
      S_FIX_N  = 8'b0100_0000,
      S_DONE   = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   logic [SW-1:0] head_ff, head_in;
   logic [SW-1:0] tail_ff, tail_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] rc_ff, rc_in;
   logic [CW-1:0] wm_ff, wm_in;
   logic          rsp_valid_ff, rsp_valid_in;

   ols_pkg::kind_type                 kind_ff, kind_in;
   logic [VW-1:0]                     val_ff, val_in;
   logic [SW-1:0]                     slot_ff, slot_in;
   logic [SW-1:0]                     p_ff, p_in;
   logic [SW-1:0]                     n_ff, n_in;
   logic [CW-1:0]                     left_ff, left_in;
   ols_pkg::status_type               status_ff, status_in;
   logic signed [ols_pkg::DATA_W-1:0] removed_ff, removed_in;
   logic                              rsp_load;

   ols_pkg::status_type               rsp_status_ff;
   logic signed [ols_pkg::DATA_W-1:0] rsp_removed_ff;
   logic [ols_pkg::COUNT_W-1:0]       rsp_count_ff;

   logic          ent_we;
   logic [SW-1:0] ent_waddr;
   logic [EW-1:0] ent_wdata;
   logic [SW-1:0] ent_raddr;
   logic [EW-1:0] ent_rdata;

   logic          free_we;
   logic [SW-1:0] free_waddr;
   logic [SW-1:0] free_raddr;
   logic [SW-1:0] free_rdata;

   logic [VW-1:0] ent_value;
   logic [SW-1:0] ent_next;
   logic [SW-1:0] ent_prev;
   logic [XW-1:0] ent_wide;
   logic          match;

   // entry layout: value, next link, prev link
   assign ent_value = ent_rdata[EW-1:2*SW];
   assign ent_next  = ent_rdata[2*SW-1:SW];
   assign ent_prev  = ent_rdata[SW-1:0];
   assign ent_wide  = XW'($signed(ent_value));
   assign match     = (kind_ff != ols_pkg::KIND_REMOVE_MATCH) || (ent_value == val_ff);

   // top of the recycled slot stack, read ahead every cycle
   assign free_raddr = SW'(rc_ff - CW'(1));
   assign free_waddr = SW'(rc_ff);

   ols_ram #(
      .WIDTH (EW),
      .DEPTH (CAPACITY)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ent_we),
      .wr_addr (ent_waddr),
      .wr_data (ent_wdata),
      .rd_addr (ent_raddr),
      .rd_data (ent_rdata)
   );

   ols_ram #(
      .WIDTH (SW),
      .DEPTH (CAPACITY)
   ) u_free_ram (
      .clock   (clock),
      .wr_en   (free_we),
      .wr_addr (free_waddr),
      .wr_data (slot_ff),
      .rd_addr (free_raddr),
      .rd_data (free_rdata)
   );

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      rc_in        = rc_ff;
      wm_in        = wm_ff;
      kind_in      = kind_ff;
      val_in       = val_ff;
      slot_in      = slot_ff;
      p_in         = p_ff;
      n_in         = n_ff;
      left_in      = left_ff;
      status_in    = status_ff;
      removed_in   = removed_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_load     = 1'b0;
      ent_we       = 1'b0;
      ent_waddr    = slot_ff;
      ent_wdata    = {val_ff, SW'(0), tail_ff};
      ent_raddr    = head_ff;
      free_we      = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_if.valid) begin
               kind_in    = req_if.kind;
               val_in     = VW'($unsigned(req_if.value));
               status_in  = ols_pkg::ST_DONE;
               removed_in = '0;
               unique case (req_if.kind)
                  ols_pkg::KIND_APPEND: begin
                     if (count_ff == CW'(CAPACITY)) begin
                        status_in = ols_pkg::ST_FULL;
                        state_in  = S_DONE;
                     end else if (rc_ff != '0) begin
                        // recycled slot: read is already under way
                        rc_in    = rc_ff - CW'(1);
                        state_in = S_ALLOC;
                     end else begin
                        slot_in  = SW'(wm_ff);
                        wm_in    = wm_ff + CW'(1);
                        state_in = S_APPEND;
                     end
                  end
                  ols_pkg::KIND_REMOVE_FIRST, ols_pkg::KIND_REMOVE_LAST,
                  ols_pkg::KIND_REMOVE_MATCH: begin
                     if (count_ff == '0) begin
                        status_in = ols_pkg::ST_EMPTY;
                        state_in  = S_DONE;
                     end else begin
                        slot_in   = (req_if.kind == ols_pkg::KIND_REMOVE_LAST) ?
                                    tail_ff : head_ff;
                        ent_raddr = slot_in;
                        left_in   = count_ff;
                        state_in  = S_SEARCH;
                     end
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_ALLOC: begin
            slot_in  = free_rdata;
            state_in = S_APPEND;
         end
         S_APPEND: begin
            ent_we    = 1'b1;
            ent_waddr = slot_ff;
            ent_wdata = {val_ff, SW'(0), tail_ff};
            if (count_ff == '0) begin
               head_in  = slot_ff;
               tail_in  = slot_ff;
               count_in = count_ff + CW'(1);
               state_in = S_DONE;
            end else begin
               ent_raddr = tail_ff;
               state_in  = S_LINK;
            end
         end
         S_LINK: begin
            // old tail entry now on the read port
            ent_we    = 1'b1;
            ent_waddr = tail_ff;
            ent_wdata = {ent_value, slot_ff, ent_prev};
            tail_in   = slot_ff;
            count_in  = count_ff + CW'(1);
            state_in  = S_DONE;
         end
         S_SEARCH: begin
            if (match) begin
               removed_in = ent_wide[ols_pkg::DATA_W-1:0];
               free_we    = 1'b1;
               rc_in      = rc_ff + CW'(1);
               count_in   = count_ff - CW'(1);
               state_in   = S_DONE;
               if (count_ff <= CW'(1)) begin
                  head_in = '0;
                  tail_in = '0;
               end else if (slot_ff == head_ff) begin
                  head_in = ent_next;
               end else if (slot_ff == tail_ff) begin
                  tail_in = ent_prev;
               end else begin
                  // middle entry: patch both neighbors
                  p_in      = ent_prev;
                  n_in      = ent_next;
                  ent_raddr = ent_prev;
                  state_in  = S_FIX_P;
               end
            end else if (left_ff == CW'(1)) begin
               status_in = ols_pkg::ST_NOTFOUND;
               state_in  = S_DONE;
            end else begin
               slot_in   = ent_next;
               ent_raddr = ent_next;
               left_in   = left_ff - CW'(1);
            end
         end
         S_FIX_P: begin
            ent_we    = 1'b1;
            ent_waddr = p_ff;
            ent_wdata = {ent_value, n_ff, ent_prev};
            ent_raddr = n_ff;
            state_in  = S_FIX_N;
         end
         S_FIX_N: begin
            ent_we    = 1'b1;
            ent_waddr = n_ff;
            ent_wdata = {ent_value, ent_next, p_ff};
            state_in  = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in = 1'b1;
               rsp_load     = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rc_ff        <= '0;
         wm_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rc_ff        <= rc_in;
         wm_ff        <= wm_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff    <= kind_in;
      val_ff     <= val_in;
      slot_ff    <= slot_in;
      p_ff       <= p_in;
      n_ff       <= n_in;
      left_ff    <= left_in;
      status_ff  <= status_in;
      removed_ff <= removed_in;
      if (rsp_load) begin
         rsp_status_ff  <= status_ff;
         rsp_removed_ff <= removed_ff;
         rsp_count_ff   <= ols_pkg::COUNT_W'(count_ff);
      end
   end

   assign req_if.ready         = (state_ff == S_IDLE);
   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.status        = rsp_status_ff;
   assign rsp_if.removed_value = rsp_removed_ff;
   assign rsp_if.entry_count   = rsp_count_ff;

endmodule
